FILE: design/trms_pkg.sv
// Shared types and constants for the true-RMS current meter.
// Used by trms_divsqrt and true_rms_current_meter; depends on nothing.
package trms_pkg;

	// Converter and millivolt widths
	localparam int SAMPLE_BITS = 12;
	localparam int RAW_W       = 12;
	localparam int MV_W        = 12;
	localparam int MV_FULL     = 3300;

	// Fixed-point widths: offsets Q12.16, squared sums, check sum
	localparam int ALPHA_W = 16;
	localparam int OFF_W   = MV_W + 16;
	localparam int SQ_W    = 48;
	localparam int CHK_W   = 24;
	localparam int CNT_W   = 12;
	localparam int MA_W    = 16;

	// Divide / square-root unit widths
	localparam int DS_W   = 48;
	localparam int DVS_W  = CNT_W;
	localparam int ROOT_W = DS_W / 2;
	localparam int REM_W  = ROOT_W + 3;
	localparam int STEP_W = 6;

	// Operation codes of the divide / square-root unit
	typedef logic ds_op_t;
	localparam ds_op_t OP_DIV  = 1'b0;
	localparam ds_op_t OP_SQRT = 1'b1;

	typedef struct packed {
		logic   start;
		ds_op_t op;
	} ds_cmd_t;

	typedef struct packed {
		logic busy;
	} ds_stat_t;

endpackage

FILE: design/trms_divsqrt.sv
// Iterative unit: 48-bit by 12-bit restoring division, or 48-bit integer square root.
// One quotient bit or one root bit per cycle. Depends on trms_pkg.
module trms_divsqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  trms_pkg::ds_cmd_t           cmd,
	input  logic [trms_pkg::DS_W-1:0]   operand,
	input  logic [trms_pkg::DVS_W-1:0]  divisor,
	output trms_pkg::ds_stat_t          stat,
	output logic [trms_pkg::DS_W-1:0]   result
);
	import trms_pkg::*;

	logic              busy_q;
	ds_op_t            op_q;
	logic [STEP_W-1:0] step_q;
	logic [DS_W-1:0]   val_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0]    div_t;
	logic              div_ge;
	logic [REM_W-1:0]  sq_r;
	logic [REM_W-1:0]  sq_trial;
	logic              sq_ge;

	// One restoring step of each operation
	always_comb begin
		div_t    = {rem_q[DVS_W-1:0], val_q[DS_W-1]};
		div_ge   = div_t >= {1'b0, dvs_q};
		sq_r     = {rem_q[REM_W-3:0], val_q[DS_W-1 -: 2]};
		sq_trial = {1'b0, root_q, 2'b01};
		sq_ge    = sq_r >= sq_trial;
	end

	// Control: busy flag and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			step_q <= (cmd.op == OP_SQRT) ? STEP_W'(ROOT_W - 1) : STEP_W'(DS_W - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= cmd.op;
			val_q  <= operand;
			dvs_q  <= divisor;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (op_q == OP_SQRT) begin
				rem_q  <= sq_ge ? (sq_r - sq_trial) : sq_r;
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				val_q  <= {val_q[DS_W-3:0], 2'b00};
			end else begin
				rem_q  <= REM_W'(div_ge ? (div_t - {1'b0, dvs_q}) : div_t);
				val_q  <= {val_q[DS_W-2:0], div_ge};
			end
		end
	end

	assign stat.busy = busy_q;
	assign result    = (op_q == OP_SQRT) ? DS_W'(root_q) : val_q;

	// A new operation only starts on an idle unit
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("divsqrt started while busy");

	// A started operation keeps the unit busy on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> busy_q)
		else $error("divsqrt did not go busy after start");

	// The division remainder always stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && op_q == OP_DIV) |-> (rem_q < REM_W'(dvs_q)))
		else $error("division remainder out of range");

endmodule

FILE: design/true_rms_current_meter.sv
// True-RMS current meter: per-sample offset tracking and squaring, burst-end RMS.
// Sequencer with one shared 28x18 multiplier; uses trms_pkg and trms_divsqrt.
// Sample beats are taken only in idle; in_stall stays high until a sample is through,
// so a new one is not taken before the last. A sample that ends a burst also runs the
// bit-serial divide and square root per channel, plus one divide for the check sum.
// Reset: offsets go to 1650 mV, sums and count to zero, registers to defaults.
module true_rms_current_meter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [trms_pkg::RAW_W-1:0]    raw_sense_a,
	input  logic [trms_pkg::RAW_W-1:0]    raw_sense_b,
	input  logic [trms_pkg::RAW_W-1:0]    raw_check,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [trms_pkg::MA_W-1:0]     current_a_ma,
	output logic [trms_pkg::MA_W-1:0]     current_b_ma,
	output logic [trms_pkg::MV_W-1:0]     check_avg_mv,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [trms_pkg::ALPHA_W-1:0]  cfg_data
);
	import trms_pkg::*;

	// Register indexes
	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_COUNT = 2'd1;
	localparam logic [1:0] REG_GAIN  = 2'd2;
	localparam logic [1:0] REG_FLOOR = 2'd3;

	// Channels
	localparam logic [1:0] CH_A   = 2'd0;
	localparam logic [1:0] CH_B   = 2'd1;
	localparam logic [1:0] CH_CHK = 2'd2;

	// Sequencer states
	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_CNV_MUL  = 5'd1;
	localparam logic [4:0] ST_CNV_EST  = 5'd2;
	localparam logic [4:0] ST_CNV_FIX  = 5'd3;
	localparam logic [4:0] ST_EMA_MUL1 = 5'd4;
	localparam logic [4:0] ST_EMA_MUL2 = 5'd5;
	localparam logic [4:0] ST_EMA_UPD  = 5'd6;
	localparam logic [4:0] ST_DEV      = 5'd7;
	localparam logic [4:0] ST_SQ_MUL   = 5'd8;
	localparam logic [4:0] ST_SQ_ACC   = 5'd9;
	localparam logic [4:0] ST_END_CHK  = 5'd10;
	localparam logic [4:0] ST_DIV_GO   = 5'd11;
	localparam logic [4:0] ST_DIV_WAIT = 5'd12;
	localparam logic [4:0] ST_SQRT_GO  = 5'd13;
	localparam logic [4:0] ST_SQRT_WT  = 5'd14;
	localparam logic [4:0] ST_GAIN_MUL = 5'd15;
	localparam logic [4:0] ST_SCALE    = 5'd16;
	localparam logic [4:0] ST_CHK_GO   = 5'd17;
	localparam logic [4:0] ST_CHK_WAIT = 5'd18;
	localparam logic [4:0] ST_EMIT     = 5'd19;

	// Datapath widths
	localparam int X_W    = SAMPLE_BITS + MV_W;
	localparam int MUL_AW = OFF_W;
	localparam int MUL_BW = 18;
	localparam int PROD_W = MUL_AW + MUL_BW;
	localparam int D_W    = 18;
	localparam int MVA_W  = MV_W + ALPHA_W;
	localparam int UPD_W  = PROD_W + 1;
	localparam int GP_W   = ROOT_W + ALPHA_W;
	localparam int MAX_W  = GP_W + 1 - 14;

	localparam logic [OFF_W-1:0] OFF_RESET = OFF_W'(MV_FULL / 2) << 16;
	localparam logic [OFF_W-1:0] OFF_MAX   = OFF_W'(MV_FULL) << 16;
	localparam logic [MV_W-1:0]  MV_MAX    = MV_W'(MV_FULL);

	// Configuration registers
	logic [ALPHA_W-1:0] alpha_q;
	logic [CNT_W-1:0]   count_q;
	logic [ALPHA_W-1:0] gain_q;
	logic [MA_W-1:0]    floor_q;

	// Control and state
	logic [4:0]         state_q;
	logic [1:0]         ch_q;
	logic [CNT_W-1:0]   idx_q;
	logic [OFF_W-1:0]   off_q [2];
	logic [SQ_W-1:0]    sq_q [2];
	logic [CHK_W-1:0]   sum_chk_q;
	logic               out_valid_q;

	// Payload
	logic [SAMPLE_BITS-1:0] raw_q [3];
	logic [MV_W-1:0]        mv_q [3];
	logic [PROD_W-1:0]      prod_q;
	logic [PROD_W-1:0]      p1_q;
	logic [MV_W-1:0]        est_q;
	logic [D_W-1:0]         d_q;
	logic [CNT_W-1:0]       n_q;
	logic [MA_W-1:0]        cur_q [2];
	logic [MA_W-1:0]        out_a_q;
	logic [MA_W-1:0]        out_b_q;
	logic [MV_W-1:0]        out_chk_q;

	// Combinational
	logic               in_acc;
	logic               out_load;
	logic               mul_en;
	logic [MUL_AW-1:0]  mul_a;
	logic [MUL_BW-1:0]  mul_b;
	logic [X_W-1:0]     xs;
	logic [X_W:0]       est_sum;
	logic [X_W:0]       est_full;
	logic [MV_W:0]      est1;
	logic [X_W:0]       fix_lhs;
	logic [X_W:0]       fix_rhs;
	logic [MV_W-1:0]    mv_new;
	logic [UPD_W-1:0]   upd;
	logic [OFF_W-1:0]   off_new;
	logic [OFF_W-1:0]   off_sel;
	logic [OFF_W-1:0]   mvq;
	logic [OFF_W-1:0]   diff;
	logic [OFF_W:0]     diff_rnd;
	logic [GP_W:0]      ma_sum;
	logic [MAX_W-1:0]   ma;
	logic [MA_W-1:0]    ma_out;
	logic [CNT_W:0]     next_idx;
	logic [CNT_W-1:0]   cnt_eff;
	logic               burst_end;

	ds_cmd_t            ds_cmd;
	ds_stat_t           ds_stat;
	logic [DS_W-1:0]    ds_operand;
	logic [DS_W-1:0]    ds_result;

	trms_divsqrt u_divsqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ds_cmd),
		.operand (ds_operand),
		.divisor (n_q),
		.stat    (ds_stat),
		.result  (ds_result)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign current_a_ma = out_a_q;
	assign current_b_ma = out_b_q;
	assign check_avg_mv = out_chk_q;

	// Shared multiplier operand select
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_CNV_MUL: begin
				mul_a = MUL_AW'(raw_q[ch_q]);
				mul_b = MUL_BW'(MV_FULL);
			end
			ST_EMA_MUL1: begin
				mul_a = off_sel;
				mul_b = MUL_BW'(18'h10000 - MUL_BW'(alpha_q));
			end
			ST_EMA_MUL2: begin
				mul_a = MUL_AW'(mv_q[ch_q]);
				mul_b = MUL_BW'(alpha_q);
			end
			ST_SQ_MUL: begin
				mul_a = MUL_AW'(d_q);
				mul_b = d_q;
			end
			ST_GAIN_MUL: begin
				mul_a = MUL_AW'(ds_result[ROOT_W-1:0]);
				mul_b = MUL_BW'(gain_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// raw * 3300 / (2^SAMPLE_BITS - 1): estimate from below, then one correction
	always_comb begin
		xs       = prod_q[X_W-1:0];
		est_sum  = (X_W+1)'(xs) + (X_W+1)'(xs >> SAMPLE_BITS);
		est_full = est_sum >> SAMPLE_BITS;
		est1     = (MV_W+1)'(est_q) + 1'b1;
		fix_lhs  = (X_W+1)'(xs) + (X_W+1)'(est1);
		fix_rhs  = (X_W+1)'(est1) << SAMPLE_BITS;
		mv_new   = (fix_lhs >= fix_rhs) ? est1[MV_W-1:0] : est_q;
	end

	// Offset update, deviation and current scaling
	always_comb begin
		off_sel  = off_q[ch_q[0]];
		upd      = UPD_W'(p1_q) + (UPD_W'(prod_q[MVA_W-1:0]) << 16) + UPD_W'(32768);
		off_new  = upd[16 +: OFF_W];
		mvq      = {mv_q[ch_q], 16'b0};
		diff     = (mvq >= off_sel) ? (mvq - off_sel) : (off_sel - mvq);
		diff_rnd = (OFF_W+1)'(diff) + (OFF_W+1)'(512);
		ma_sum   = (GP_W+1)'(prod_q[GP_W-1:0]) + (GP_W+1)'(8192);
		ma       = ma_sum[GP_W:14];
		if (ma < MAX_W'(floor_q)) begin
			ma_out = '0;
		end else if (ma > MAX_W'({MA_W{1'b1}})) begin
			ma_out = '1;
		end else begin
			ma_out = ma[MA_W-1:0];
		end
	end

	// Burst end test; a zero count acts as one
	always_comb begin
		cnt_eff   = (count_q == '0) ? CNT_W'(1) : count_q;
		next_idx  = (CNT_W+1)'(idx_q) + 1'b1;
		burst_end = !(next_idx < (CNT_W+1)'(cnt_eff));
	end

	// Divide / square-root commands
	always_comb begin
		ds_cmd.start = (state_q == ST_DIV_GO) || (state_q == ST_SQRT_GO) ||
			(state_q == ST_CHK_GO);
		ds_cmd.op    = (state_q == ST_SQRT_GO) ? OP_SQRT : OP_DIV;
		case (state_q)
			ST_SQRT_GO: ds_operand = ds_result;
			ST_CHK_GO:  ds_operand = DS_W'(sum_chk_q);
			default:    ds_operand = sq_q[ch_q[0]];
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_W'(66);
			count_q <= CNT_W'(200);
			gain_q  <= ALPHA_W'(256);
			floor_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data;
				REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				REG_GAIN:  gain_q  <= cfg_data;
				REG_FLOOR: floor_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= CH_A;
			idx_q       <= '0;
			off_q[0]    <= OFF_RESET;
			off_q[1]    <= OFF_RESET;
			sq_q[0]     <= '0;
			sq_q[1]     <= '0;
			sum_chk_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						ch_q    <= CH_A;
						state_q <= ST_CNV_MUL;
					end
				end
				ST_CNV_MUL: state_q <= ST_CNV_EST;
				ST_CNV_EST: state_q <= ST_CNV_FIX;
				ST_CNV_FIX: begin
					if (ch_q == CH_CHK) begin
						sum_chk_q <= sum_chk_q + CHK_W'(mv_new);
						ch_q      <= CH_A;
						state_q   <= ST_EMA_MUL1;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_CNV_MUL;
					end
				end
				ST_EMA_MUL1: state_q <= ST_EMA_MUL2;
				ST_EMA_MUL2: state_q <= ST_EMA_UPD;
				ST_EMA_UPD: begin
					off_q[ch_q[0]] <= off_new;
					state_q        <= ST_DEV;
				end
				ST_DEV:    state_q <= ST_SQ_MUL;
				ST_SQ_MUL: state_q <= ST_SQ_ACC;
				ST_SQ_ACC: begin
					sq_q[ch_q[0]] <= sq_q[ch_q[0]] + SQ_W'(prod_q[2*D_W-1:0]);
					if (ch_q == CH_B) begin
						state_q <= ST_END_CHK;
					end else begin
						ch_q    <= CH_B;
						state_q <= ST_EMA_MUL1;
					end
				end
				ST_END_CHK: begin
					if (burst_end) begin
						ch_q    <= CH_A;
						state_q <= ST_DIV_GO;
					end else begin
						idx_q   <= next_idx[CNT_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (!ds_stat.busy) begin
						state_q <= ST_SQRT_GO;
					end
				end
				ST_SQRT_GO: state_q <= ST_SQRT_WT;
				ST_SQRT_WT: begin
					if (!ds_stat.busy) begin
						state_q <= ST_GAIN_MUL;
					end
				end
				ST_GAIN_MUL: state_q <= ST_SCALE;
				ST_SCALE: begin
					if (ch_q == CH_A) begin
						ch_q    <= CH_B;
						state_q <= ST_DIV_GO;
					end else begin
						state_q <= ST_CHK_GO;
					end
				end
				ST_CHK_GO: state_q <= ST_CHK_WAIT;
				ST_CHK_WAIT: begin
					if (!ds_stat.busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						idx_q       <= '0;
						sq_q[0]     <= '0;
						sq_q[1]     <= '0;
						sum_chk_q   <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_q[CH_A]   <= SAMPLE_BITS'(raw_sense_a);
			raw_q[CH_B]   <= SAMPLE_BITS'(raw_sense_b);
			raw_q[CH_CHK] <= SAMPLE_BITS'(raw_check);
		end
		if (mul_en) begin
			prod_q <= PROD_W'(mul_a * mul_b);
		end
		if (state_q == ST_CNV_EST) begin
			est_q <= est_full[MV_W-1:0];
		end
		if (state_q == ST_CNV_FIX) begin
			mv_q[ch_q] <= mv_new;
		end
		if (state_q == ST_EMA_MUL2) begin
			p1_q <= prod_q;
		end
		if (state_q == ST_DEV) begin
			d_q <= diff_rnd[10 +: D_W];
		end
		if (state_q == ST_END_CHK) begin
			n_q <= next_idx[CNT_W-1:0];
		end
		if (state_q == ST_SCALE) begin
			cur_q[ch_q[0]] <= ma_out;
		end
		if (out_load) begin
			out_a_q   <= cur_q[0];
			out_b_q   <= cur_q[1];
			out_chk_q <= ds_result[MV_W-1:0];
		end
	end

	// Offsets never leave the millivolt range
	a_off_range: assert property (@(posedge clk) disable iff (!arst_n)
		(off_q[0] <= OFF_MAX) && (off_q[1] <= OFF_MAX))
		else $error("DC offset out of range");

	// The mean check voltage cannot exceed full scale
	a_chk_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_chk_q <= MV_MAX))
		else $error("check average out of range");

	// Emitting a result clears the burst sums and sample count
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (idx_q == '0 && sum_chk_q == '0 && sq_q[0] == '0 && sq_q[1] == '0))
		else $error("burst sums not cleared after result");

	// A new result is never loaded over one that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(out_a_q) && $stable(out_chk_q))
		else $error("held result overwritten");

endmodule

FILE: sim/trms_tb_pkg.sv
`timescale 1ns / 100ps
// Register indexes of the meter's configuration port, shared by the testbench files.
// Depends on nothing.
package trms_tb_pkg;

	typedef enum logic [1:0] {
		REG_ALPHA = 2'd0,
		REG_COUNT = 2'd1,
		REG_GAIN  = 2'd2,
		REG_FLOOR = 2'd3
	} reg_index_t;

endpackage

FILE: sim/trms_checker.sv
`timescale 1ns / 100ps
// Checker for the true-RMS current meter: follows the register port and the sample beats,
// predicts each burst reading and compares it with the result beats. Uses trms_pkg, trms_tb_pkg.
module trms_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [trms_pkg::RAW_W-1:0]    raw_sense_a,
	input  logic [trms_pkg::RAW_W-1:0]    raw_sense_b,
	input  logic [trms_pkg::RAW_W-1:0]    raw_check,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [trms_pkg::MA_W-1:0]     current_a_ma,
	input  logic [trms_pkg::MA_W-1:0]     current_b_ma,
	input  logic [trms_pkg::MV_W-1:0]     check_avg_mv,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [trms_pkg::ALPHA_W-1:0]  cfg_data,
	output int                            fail_count,
	output int                            pending,
	output int                            samples_seen,
	output int                            readings_seen
);
	import trms_pkg::*;
	import trms_tb_pkg::*;

	typedef struct packed {
		logic [MA_W-1:0] current_a;
		logic [MA_W-1:0] current_b;
		logic [MV_W-1:0] check_mv;
	} reading_t;

	localparam logic [OFF_W-1:0]   DC_MID     = 1650 << 16;
	localparam logic [ALPHA_W-1:0] ALPHA_DEF  = 66;
	localparam logic [CNT_W-1:0]   COUNT_DEF  = 200;
	localparam logic [ALPHA_W-1:0] GAIN_DEF   = 256;

	// Register copies
	logic [ALPHA_W-1:0] alpha_r, gain_r, floor_r;
	logic [CNT_W-1:0]   count_r;

	// Meter state
	logic [OFF_W-1:0] off_a, off_b;
	logic [SQ_W-1:0]  sq_a, sq_b;
	logic [CHK_W-1:0] chk_sum;
	logic [CNT_W-1:0] burst_idx;

	reading_t       readings_q[$];
	reading_t       want, got;
	logic [MV_W-1:0] mv_a, mv_b, mv_c;
	int             burst_len, n;
	int             predicted_n;

	assign pending = predicted_n - readings_seen;

	// raw code to whole millivolts, truncating
	function automatic logic [MV_W-1:0] raw_to_mv(input logic [RAW_W-1:0] raw);
		bit [31:0] full_scale, prod;
		full_scale = (32'd1 << SAMPLE_BITS) - 32'd1;
		prod = raw;
		prod = (prod & full_scale) * MV_FULL;
		return prod / full_scale;
	endfunction

	// exponential offset update, round to nearest, Q12.16
	function automatic logic [OFF_W-1:0] ema_step(input logic [OFF_W-1:0] off,
			input logic [MV_W-1:0] mv, input logic [ALPHA_W-1:0] alpha);
		bit [63:0] mvq, o, a, acc;
		mvq = mv;
		mvq = mvq << 16;
		o = off;
		a = alpha;
		acc = o * (64'd65536 - a) + mvq * a + 64'd32768;
		return acc >> 16;
	endfunction

	// squared deviation from the new offset, rounded to Q.6 mV, squared to Q.12 mV squared
	function automatic bit [63:0] dev_square(input logic [OFF_W-1:0] off,
			input logic [MV_W-1:0] mv);
		bit [63:0] mvq, o, d;
		mvq = mv;
		mvq = mvq << 16;
		o = off;
		d = (mvq >= o) ? mvq - o : o - mvq;
		d = (d + 64'd512) >> 10;
		return d * d;
	endfunction

	function automatic bit [63:0] int_sqrt(input bit [63:0] v);
		bit [63:0] r, b;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// mean square to milliamps: root, Q8.8 gain, floor, then saturation
	function automatic logic [MA_W-1:0] rms_to_ma(input logic [SQ_W-1:0] sum, input int cnt,
			input logic [ALPHA_W-1:0] gain, input logic [ALPHA_W-1:0] floor_ma);
		bit [63:0] mean, nn, rms, ma, g, fl;
		mean = sum;
		nn = cnt;
		g = gain;
		fl = floor_ma;
		rms = int_sqrt(mean / nn);
		ma = (rms * g + 64'd8192) >> 14;
		if (ma < fl)
			ma = 64'd0;
		if (ma > 64'd65535)
			ma = 64'd65535;
		return ma[MA_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_r = ALPHA_DEF;
			count_r = COUNT_DEF;
			gain_r = GAIN_DEF;
			floor_r = '0;
			off_a = DC_MID;
			off_b = DC_MID;
			sq_a = '0;
			sq_b = '0;
			chk_sum = '0;
			burst_idx = '0;
			readings_q.delete();
			predicted_n = 0;
			readings_seen = 0;
			samples_seen = 0;
			fail_count = 0;
		end else begin
			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				got = {current_a_ma, current_b_ma, check_avg_mv};
				if (readings_q.size() == 0) begin
					$error("reading beat with none predicted: a=%0d b=%0d check=%0d",
						current_a_ma, current_b_ma, check_avg_mv);
					fail_count++;
				end else begin
					want = readings_q.pop_front();
					readings_seen++;
					if (got.current_a !== want.current_a) begin
						$error("current_a_ma: expected %0d, got %0d",
							want.current_a, got.current_a);
						fail_count++;
					end
					if (got.current_b !== want.current_b) begin
						$error("current_b_ma: expected %0d, got %0d",
							want.current_b, got.current_b);
						fail_count++;
					end
					if (got.check_mv !== want.check_mv) begin
						$error("check_avg_mv: expected %0d, got %0d",
							want.check_mv, got.check_mv);
						fail_count++;
					end
				end
			end

			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_ALPHA: alpha_r = cfg_data;
					REG_COUNT: count_r = cfg_data[CNT_W-1:0];
					REG_GAIN:  gain_r = cfg_data;
					REG_FLOOR: floor_r = cfg_data;
					default: ;
				endcase
			end

			// sample beat: track offsets, accumulate, close the burst when due
			if (in_valid && !in_stall) begin
				samples_seen++;
				mv_a = raw_to_mv(raw_sense_a);
				mv_b = raw_to_mv(raw_sense_b);
				mv_c = raw_to_mv(raw_check);
				off_a = ema_step(off_a, mv_a, alpha_r);
				sq_a = sq_a + dev_square(off_a, mv_a);
				off_b = ema_step(off_b, mv_b, alpha_r);
				sq_b = sq_b + dev_square(off_b, mv_b);
				chk_sum = chk_sum + mv_c;
				// zero count behaves as one
				burst_len = (count_r == 0) ? 1 : count_r;
				n = burst_idx + 1;
				if (n < burst_len) begin
					burst_idx = burst_idx + 1;
				end else begin
					want.current_a = rms_to_ma(sq_a, n, gain_r, floor_r);
					want.current_b = rms_to_ma(sq_b, n, gain_r, floor_r);
					want.check_mv = chk_sum / n;
					readings_q.push_back(want);
					predicted_n++;
					sq_a = '0;
					sq_b = '0;
					chk_sum = '0;
					burst_idx = '0;
				end
			end
		end
	end

endmodule

FILE: sim/tb_true_rms_current_meter.sv
`timescale 1ns / 100ps
// Testbench top for the true-RMS current meter: clock, reset, sample and register stimulus,
// random input gaps and output stalls, verdict. Uses trms_pkg, trms_tb_pkg and trms_checker.
module tb_true_rms_current_meter;
	import trms_pkg::*;
	import trms_tb_pkg::*;

	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES   = 600;
	localparam int RANDOM_ITEMS  = 1650;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [RAW_W-1:0]    raw_sense_a, raw_sense_b, raw_check;
	logic                out_valid;
	logic                out_stall;
	logic [MA_W-1:0]     current_a_ma, current_b_ma;
	logic [MV_W-1:0]     check_avg_mv;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [ALPHA_W-1:0]  cfg_data;

	int fail_count, pending, samples_seen, readings_seen;
	int reg_writes;
	bit idle_on;
	bit hold_off_req;

	true_rms_current_meter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.raw_sense_a  (raw_sense_a),
		.raw_sense_b  (raw_sense_b),
		.raw_check    (raw_check),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.current_a_ma (current_a_ma),
		.current_b_ma (current_b_ma),
		.check_avg_mv (check_avg_mv),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	trms_checker meter_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.raw_sense_a   (raw_sense_a),
		.raw_sense_b   (raw_sense_b),
		.raw_check     (raw_check),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.current_a_ma  (current_a_ma),
		.current_b_ma  (current_b_ma),
		.check_avg_mv  (check_avg_mv),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.samples_seen  (samples_seen),
		.readings_seen (readings_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// one register write, enable left high for a following write
	task automatic write_reg(input reg_index_t idx, input logic [ALPHA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		reg_writes++;
	endtask

	task automatic set_meter_config(input logic [ALPHA_W-1:0] alpha, count, gain, floor_ma);
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_COUNT, count);
		write_reg(REG_GAIN, gain);
		write_reg(REG_FLOOR, floor_ma);
		cfg_we <= 1'b0;
	endtask

	// present one sample beat, maybe after a gap; returns at the falling edge after acceptance
	task automatic send_sample(input logic [RAW_W-1:0] a, b, c);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 15);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		raw_sense_a <= a;
		raw_sense_b <= b;
		raw_check <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// wait for every predicted reading, then let a burst-end computation drain
	task automatic settle_meter();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sensor waveform around a centre, with the odd full-range outlier
	function automatic logic [RAW_W-1:0] wave_sample(input int centre, input int swing);
		int v;
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 4095);
		v = $urandom_range(0, 2 * swing);
		v = v + centre - swing;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v;
	endfunction

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int stall_left, free_left;
		stall_left = 0;
		free_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && free_left == 0) begin
				if (idle_on && $urandom_range(0, 2) == 0)
					stall_left = $urandom_range(1, 15);
				else
					free_left = $urandom_range(1, 20);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (free_left > 0)
					free_left--;
			end
		end
	end

	initial begin : stimulus
		int sent, phase_items, centre, swing, cnt, k;
		logic [ALPHA_W-1:0] alpha_w, count_w, gain_w, floor_w;

		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_sense_a = '0;
		raw_sense_b = '0;
		raw_check = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ALPHA;
		cfg_data = '0;
		reg_writes = 0;
		idle_on = 1'b1;
		hold_off_req = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: partial burst, then count lowered so the next beat closes it
		send_sample(12'h000, 12'hFFF, 12'h000);
		send_sample(12'hFFF, 12'h000, 12'hFFF);
		send_sample(12'h800, 12'h7FF, 12'h001);
		send_sample(12'hAAA, 12'h555, 12'hFFF);
		send_sample(12'h000, 12'h000, 12'h000);
		settle_meter();
		write_reg(REG_COUNT, 16'd2);
		cfg_we <= 1'b0;
		send_sample(12'hFFF, 12'hFFF, 12'hFFF);
		settle_meter();

		// frozen offset, zero count acts as one
		set_meter_config(16'd0, 16'd0, 16'd256, 16'd0);
		send_sample(12'h000, 12'h000, 12'h000);
		send_sample(12'hFFF, 12'hFFF, 12'hFFF);
		send_sample(12'h000, 12'hFFF, 12'h800);
		send_sample(12'hFFF, 12'h000, 12'h001);
		settle_meter();

		// fastest tracking, top gain, top floor; count word with junk above bit 11
		set_meter_config(16'hFFFF, 16'hF001, 16'hFFFF, 16'hFFFF);
		send_sample(12'h000, 12'hFFF, 12'hFFF);
		send_sample(12'hFFF, 12'h000, 12'h000);
		send_sample(12'h800, 12'h800, 12'h800);
		settle_meter();

		// zero gain gives zero current
		set_meter_config(16'd1, 16'd3, 16'd0, 16'd0);
		send_sample(12'h123, 12'hEDC, 12'h5A5);
		send_sample(12'hFFF, 12'h000, 12'hA5A);
		send_sample(12'h000, 12'hFFF, 12'h3C3);
		settle_meter();

		// longest count, then lowered below the samples already taken
		set_meter_config(16'd32768, 16'd4095, 16'd256, 16'd100);
		for (k = 0; k < 4; k++)
			send_sample(wave_sample(2048, 2000), wave_sample(1000, 900), $urandom_range(0, 4095));
		settle_meter();
		write_reg(REG_COUNT, 16'd2);
		cfg_we <= 1'b0;
		send_sample(12'hFFF, 12'h000, 12'hFFF);
		settle_meter();

		// back-pressure: one reading per beat while the receiver holds off
		set_meter_config($urandom_range(0, 65535), 16'd1, 16'd256, 16'd0);
		hold_off_req = 1'b1;
		for (k = 0; k < 30; k++)
			send_sample(wave_sample(2048, 1500), wave_sample(2048, 1500), $urandom_range(0, 4095));
		settle_meter();

		// random phases: new settings, then a waveform of random length
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (RANDOM_ITEMS - sent < 250)
				idle_on = 1'b0;
			case ($urandom_range(0, 5))
				0: alpha_w = 16'd0;
				1: alpha_w = 16'hFFFF;
				2: alpha_w = $urandom_range(1, 400);
				default: alpha_w = $urandom_range(0, 65535);
			endcase
			case ($urandom_range(0, 7))
				0: cnt = 0;
				1: cnt = 1;
				2: cnt = 2;
				3, 4: cnt = $urandom_range(3, 8);
				5, 6: cnt = $urandom_range(9, 40);
				default: cnt = $urandom_range(41, 120);
			endcase
			count_w = cnt;
			if ($urandom_range(0, 5) == 0)
				count_w[15:12] = $urandom_range(1, 15);
			case ($urandom_range(0, 4))
				0: gain_w = 16'hFFFF;
				1: gain_w = $urandom_range(0, 1024);
				default: gain_w = $urandom_range(0, 65535);
			endcase
			case ($urandom_range(0, 4))
				0, 1: floor_w = 16'd0;
				2: floor_w = 16'hFFFF;
				3: floor_w = $urandom_range(0, 4000);
				default: floor_w = $urandom_range(0, 65535);
			endcase
			set_meter_config(alpha_w, count_w, gain_w, floor_w);

			centre = $urandom_range(0, 4095);
			swing = $urandom_range(0, 2048);
			phase_items = $urandom_range(60, 160);
			if (phase_items > RANDOM_ITEMS - sent)
				phase_items = RANDOM_ITEMS - sent;
			for (k = 0; k < phase_items; k++)
				send_sample(wave_sample(centre, swing), wave_sample(4095 - centre, swing),
					$urandom_range(0, 4095));
			sent += phase_items;
			settle_meter();
		end

		$display("Run covered %0d sample beats and %0d burst readings over %0d register writes.",
			samples_seen, readings_seen, reg_writes);
		if (pending != 0)
			$error("%0d predicted readings never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
design/trms_pkg.sv
design/trms_divsqrt.sv
design/true_rms_current_meter.sv
sim/trms_tb_pkg.sv
sim/trms_checker.sv
sim/tb_true_rms_current_meter.sv
